@@ hw/rtl/crc4ftg_pkg.sv @@
// ----------------------------------------------------------------------------
// crc4ftg_pkg
// Shared types, constants and CRC helpers for the frame tail generator.
// ----------------------------------------------------------------------------
package crc4ftg_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned NIB_W       = 4;
    localparam int unsigned NCH_W       = 3;
    localparam int unsigned POS_W       = 3;
    localparam int unsigned LEN_W       = 4;

    localparam logic [NCH_W-1:0] NUM_CH_RESET = 3'd6;
    localparam logic [NCH_W-1:0] MAX_CHANNELS = 3'd6;
    localparam logic [LEN_W-1:0] MAX_PAYLOAD  = 4'd7;

    // queue between front and back
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

    // x^4+x+1 nibble table
    localparam logic [NIB_W-1:0] CRC_TABLE [16] = '{
        4'd0, 4'd3, 4'd6, 4'd5, 4'd12, 4'd15, 4'd10, 4'd9,
        4'd11, 4'd8, 4'd13, 4'd14, 4'd7, 4'd4, 4'd1, 4'd2
    };

    typedef struct packed {
        logic [BYTE_W-1:0] tail;   // tail byte, valid when last is set
        logic              last;   // closes the frame
        logic [BYTE_W-1:0] data;   // payload byte
    } q_entry_t;

    typedef enum logic {
        BK_PAYLOAD,
        BK_TAIL
    } back_state_t;

    function automatic logic [NIB_W-1:0] crc_step(input logic [NIB_W-1:0] crc,
                                                  input logic [NIB_W-1:0] nib);
        crc_step = CRC_TABLE[crc] ^ nib;
    endfunction

    function automatic logic [LEN_W-1:0] payload_len(input logic [NCH_W-1:0] nch);
        logic [NCH_W-1:0] n;
        n = (nch > MAX_CHANNELS) ? MAX_CHANNELS : nch;
        if (n >= 3'd3 && n <= 3'd5)
            payload_len = {1'b0, n} + 4'd2;
        else
            payload_len = {1'b0, n} + 4'd1;
    endfunction

endpackage

@@ hw/rtl/crc4ftg_front.sv @@
// ----------------------------------------------------------------------------
// crc4ftg_front
// Accepts payload bytes, runs the CRC, flags the frame's last byte and
// precomputes its tail byte.
// ----------------------------------------------------------------------------
module crc4ftg_front
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [crc4ftg_pkg::NCH_W-1:0]           cfg_wdata,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [crc4ftg_pkg::BYTE_W-1:0]          in_data,
    input  logic                                    q_full,
    output logic                                    q_push,
    output crc4ftg_pkg::q_entry_t                   q_wentry
);

    logic [crc4ftg_pkg::NCH_W-1:0] num_ch_reg;
    logic [crc4ftg_pkg::NIB_W-1:0] crc_reg, crc_next;
    logic [crc4ftg_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [crc4ftg_pkg::NIB_W-1:0] seq_reg, seq_next;

    logic [crc4ftg_pkg::NIB_W-1:0] crc_hi, crc_lo, crc_seq;
    logic [crc4ftg_pkg::LEN_W-1:0] len, taken;
    logic                          is_last;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        crc_hi  = crc4ftg_pkg::crc_step(crc_reg, in_data[7:4]);
        crc_lo  = crc4ftg_pkg::crc_step(crc_hi, in_data[3:0]);
        crc_seq = crc4ftg_pkg::crc_step(crc_lo, seq_reg);
        len     = crc4ftg_pkg::payload_len(num_ch_reg);
        taken   = {1'b0, pos_reg} + 4'd1;
        is_last = !(taken < len && taken <= crc4ftg_pkg::MAX_PAYLOAD);

        q_wentry.data = in_data;
        q_wentry.last = is_last;
        q_wentry.tail = {seq_reg, crc4ftg_pkg::CRC_TABLE[crc_seq]};

        crc_next = crc_reg;
        pos_next = pos_reg;
        seq_next = seq_reg;
        if (q_push)
        begin
            if (is_last)
            begin
                crc_next = '0;
                pos_next = '0;
                seq_next = seq_reg + 4'd1;
            end
            else
            begin
                crc_next = crc_lo;
                pos_next = taken[crc4ftg_pkg::POS_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_ch_reg <= crc4ftg_pkg::NUM_CH_RESET;
            crc_reg    <= '0;
            pos_reg    <= '0;
            seq_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
                num_ch_reg <= cfg_wdata;
            crc_reg <= crc_next;
            pos_reg <= pos_next;
            seq_reg <= seq_next;
        end
    end

endmodule

@@ hw/rtl/crc4ftg_queue.sv @@
// ----------------------------------------------------------------------------
// crc4ftg_queue
// Small FIFO of classified bytes between front and back.
// ----------------------------------------------------------------------------
module crc4ftg_queue
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  crc4ftg_pkg::q_entry_t  wentry,
    output logic                   full,
    input  logic                   pop,
    output crc4ftg_pkg::q_entry_t  rentry,
    output logic                   empty
);

    crc4ftg_pkg::q_entry_t           mem [crc4ftg_pkg::Q_DEPTH];
    crc4ftg_pkg::q_entry_t           rentry_reg;
    logic [crc4ftg_pkg::Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg, rd_ptr_next;
    logic [crc4ftg_pkg::Q_CNT_W-1:0] cnt_reg, cnt_next;

    assign full   = (cnt_reg == crc4ftg_pkg::Q_CNT_W'(crc4ftg_pkg::Q_DEPTH));
    assign empty  = (cnt_reg == '0);
    assign rentry = rentry_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
    end

    // head entry is prefetched; a write into the head slot bypasses
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wentry;
        if (push && wr_ptr_reg == rd_ptr_next)
            rentry_reg <= wentry;
        else
            rentry_reg <= mem[rd_ptr_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("pop from empty queue");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != '0 && cnt_reg != crc4ftg_pkg::Q_CNT_W'(crc4ftg_pkg::Q_DEPTH))
        |-> (wr_ptr_reg - rd_ptr_reg) == cnt_reg[crc4ftg_pkg::Q_PTR_W-1:0])
        else $error("queue pointers disagree with count");

endmodule

@@ hw/rtl/crc4ftg_back.sv @@
// ----------------------------------------------------------------------------
// crc4ftg_back
// Drains the queue into the output register, inserting the tail byte
// after the frame's last payload byte.
// ----------------------------------------------------------------------------
module crc4ftg_back
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_empty,
    input  crc4ftg_pkg::q_entry_t          q_rentry,
    output logic                           q_pop,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [crc4ftg_pkg::BYTE_W-1:0] out_data,
    output logic                           out_last
);

    crc4ftg_pkg::back_state_t          state_reg, state_next;
    logic                              out_valid_reg, out_valid_next;
    logic [crc4ftg_pkg::BYTE_W-1:0]    out_byte_reg, out_byte_next;
    logic                              out_last_reg, out_last_next;
    logic [crc4ftg_pkg::BYTE_W-1:0]    tail_reg, tail_next;
    logic                              load;

    assign out_valid = out_valid_reg;
    assign out_data  = out_byte_reg;
    assign out_last  = out_last_reg;
    assign load      = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        tail_next      = tail_reg;
        q_pop          = 1'b0;
        if (load)
        begin
            case (state_reg)
                crc4ftg_pkg::BK_PAYLOAD:
                begin
                    out_valid_next = !q_empty;
                    out_byte_next  = q_rentry.data;
                    out_last_next  = 1'b0;
                    if (!q_empty)
                    begin
                        q_pop = 1'b1;
                        if (q_rentry.last)
                        begin
                            tail_next  = q_rentry.tail;
                            state_next = crc4ftg_pkg::BK_TAIL;
                        end
                    end
                end
                crc4ftg_pkg::BK_TAIL:
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = tail_reg;
                    out_last_next  = 1'b1;
                    state_next     = crc4ftg_pkg::BK_PAYLOAD;
                end
                default:
                begin
                    state_next = crc4ftg_pkg::BK_PAYLOAD;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= crc4ftg_pkg::BK_PAYLOAD;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        tail_reg     <= tail_next;
    end

    // a pending tail always sits behind a shown payload byte
    a_tail_after_payload: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == crc4ftg_pkg::BK_TAIL |-> out_valid_reg && !out_last_reg)
        else $error("tail pending without payload byte in output register");

endmodule

@@ hw/rtl/crc4_frame_tail_generator.sv @@
// ----------------------------------------------------------------------------
// crc4_frame_tail_generator
// Passes frame payload bytes through and appends a tail byte with a
// sequence number and a CRC-4 (x^4+x+1) over the payload and sequence.
// ----------------------------------------------------------------------------
//
//  port group   dir  fields (low bit first)        note
//  s_*          in   tdata: data_byte[7:0]         payload bytes
//  m_*          out  tdata: out_byte[7:0]          payload pass-through + tail
//                    tlast: frame_end              high on the tail byte
//  cfg_*        in   wdata: num_channels[2:0]      written when cfg_we high
//
//  One payload byte is accepted per cycle while the queue has room; the CRC
//  for it (two nibble table steps, plus the sequence fold on a closing byte)
//  is done in the front stage in that same cycle.
//  The closing byte of a frame is followed on the output by its tail byte,
//  so a frame of N bytes takes N+1 output transfers.
//  A four-entry queue separates front and back; output stalls only fill it,
//  and s_tready drops when it is full.
//  Reset (rst_n low, asynchronous) clears CRC, byte position and sequence
//  and sets num_channels to 6. No clearing pass is needed.
// ----------------------------------------------------------------------------
module crc4_frame_tail_generator
(
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   cfg_we,
    input  logic [crc4ftg_pkg::NCH_W-1:0]          cfg_wdata,  // num_channels

    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [crc4ftg_pkg::BYTE_W-1:0]         s_tdata,    // data_byte

    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [crc4ftg_pkg::BYTE_W-1:0]         m_tdata,    // out_byte
    output logic                                   m_tlast     // frame_end
);

    // front -> queue
    logic                  q_push;
    crc4ftg_pkg::q_entry_t q_wentry;
    logic                  q_full;

    // queue -> back
    logic                  q_pop;
    crc4ftg_pkg::q_entry_t q_rentry;
    logic                  q_empty;

    // Front: classifies each byte (last of frame or not) and computes the
    // tail byte on the closing transfer, so the back end only sequences.
    crc4ftg_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_wentry  (q_wentry)
    );

    crc4ftg_queue u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wentry (q_wentry),
        .full   (q_full),
        .pop    (q_pop),
        .rentry (q_rentry),
        .empty  (q_empty)
    );

    // Back: registered output; inserts the tail transfer after a closing byte.
    crc4ftg_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_rentry  (q_rentry),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule
